/* sv/apir_pkg.sv */
// Package for the affine pixel index remap core.
// Field widths, register indexes and reset values; no dependencies.
package apir_pkg;

	// payload and register field widths
	localparam int IDX_BITS  = 24;
	localparam int DIM_BITS  = 13;
	localparam int COEF_BITS = 19;
	localparam int OFF_BITS  = 22;
	localparam int OFF_FRAC  = 8;

	// APB port
	localparam int ADDR_BITS = 5;
	localparam int DATA_BITS = 32;

	// divider: quotient bits retired per pipeline stage
	localparam int DIV_BPS    = 4;
	localparam int DIV_STAGES = IDX_BITS / DIV_BPS;

	// register indexes
	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_XX     = 3'd2;
	localparam logic [2:0] REG_XY     = 3'd3;
	localparam logic [2:0] REG_YX     = 3'd4;
	localparam logic [2:0] REG_YY     = 3'd5;
	localparam logic [2:0] REG_OFFX   = 3'd6;
	localparam logic [2:0] REG_OFFY   = 3'd7;

	// reset values
	localparam logic [DIM_BITS-1:0]  RST_DIM  = 13'd512;
	localparam logic [COEF_BITS-1:0] RST_UNIT = 19'd65536;

	typedef logic [IDX_BITS-1:0] idx_t;

endpackage

/* sv/affine_pixel_index_remap_core.sv */
// Affine pixel index remap core: index split, affine map, clamp, corner emit.
// Depends on apir_pkg.
//
// channel  | direction | handshake           | payload
// pix      | in        | pix_valid/pix_ready | pixel_index, roi_last
// tgt      | out       | tgt_valid/tgt_ready | target_index, point_last, roi_end
// apb      | in        | psel/penable/pready | paddr, pwdata, prdata
//
// The pipeline has 6 divider stages (4 quotient bits each), then multiply,
// sum, clamp, index, and the corner emitter register.
// An input enters every cycle while the pipeline is not held; the emitter sends
// one result per cycle while tgt_ready is high, and an item gives 1, 2 or 4 results.
// The pipeline moves as one; it holds while the emitter is full, losing nothing.
// Reset clears valid bits and loads the register reset values.
module affine_pixel_index_remap_core #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  logic [apir_pkg::IDX_BITS-1:0]    pixel_index,
	input  logic                             roi_last,
	output logic                             tgt_valid,
	input  logic                             tgt_ready,
	output logic [apir_pkg::IDX_BITS-1:0]    target_index,
	output logic                             point_last,
	output logic                             roi_end,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [apir_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [apir_pkg::DATA_BITS-1:0]   pwdata,
	output logic [apir_pkg::DATA_BITS-1:0]   prdata,
	output logic                             pready
);
	import apir_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int LIM = 1 << COORD_BITS;
	localparam int SW  = COEF_BITS + IDX_BITS + 4;
	localparam int XP  = COEF_BITS + CB + 1;
	localparam int YP  = COEF_BITS + IDX_BITS + 1;

	// configuration registers
	logic [DIM_BITS-1:0]         width_q, height_q;
	logic signed [COEF_BITS-1:0] cxx_q, cxy_q, cyx_q, cyy_q;
	logic signed [OFF_BITS-1:0]  offx_q, offy_q;
	logic                        wr_en;
	logic [2:0]                  reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_DIM;
			height_q <= RST_DIM;
			cxx_q    <= RST_UNIT;
			cxy_q    <= '0;
			cyx_q    <= '0;
			cyy_q    <= RST_UNIT;
			offx_q   <= '0;
			offy_q   <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_WIDTH:  width_q  <= pwdata[DIM_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_BITS-1:0];
				REG_XX:     cxx_q    <= pwdata[COEF_BITS-1:0];
				REG_XY:     cxy_q    <= pwdata[COEF_BITS-1:0];
				REG_YX:     cyx_q    <= pwdata[COEF_BITS-1:0];
				REG_YY:     cyy_q    <= pwdata[COEF_BITS-1:0];
				REG_OFFX:   offx_q   <= pwdata[OFF_BITS-1:0];
				REG_OFFY:   offy_q   <= pwdata[OFF_BITS-1:0];
				default:    ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = DATA_BITS'(width_q);
			REG_HEIGHT: prdata = DATA_BITS'(height_q);
			REG_XX:     prdata = DATA_BITS'(unsigned'(cxx_q));
			REG_XY:     prdata = DATA_BITS'(unsigned'(cxy_q));
			REG_YX:     prdata = DATA_BITS'(unsigned'(cyx_q));
			REG_YY:     prdata = DATA_BITS'(unsigned'(cyy_q));
			REG_OFFX:   prdata = DATA_BITS'(unsigned'(offx_q));
			REG_OFFY:   prdata = DATA_BITS'(unsigned'(offy_q));
			default:    prdata = '0;
		endcase
	end

	// saturated dimensions
	logic [CB:0] w_eff, h_eff;
	always_comb begin
		if (width_q == '0)          w_eff = (CB+1)'(1);
		else if (32'(width_q) > LIM) w_eff = (CB+1)'(LIM);
		else                        w_eff = (CB+1)'(width_q);
		if (height_q == '0)          h_eff = (CB+1)'(1);
		else if (32'(height_q) > LIM) h_eff = (CB+1)'(LIM);
		else                         h_eff = (CB+1)'(height_q);
	end

	// global advance: move unless the last stage is blocked
	logic en, emit_free;
	logic ix_v_s4;

	assign en        = emit_free | ~ix_v_s4;
	assign pix_ready = en;

	// divider pipeline: restoring, DIV_BPS quotient bits per stage
	logic [CB-1:0]       d_rem_s [1:DIV_STAGES];
	logic [IDX_BITS-1:0] d_q_s   [1:DIV_STAGES];
	logic                d_l_s   [1:DIV_STAGES];
	logic                d_v_s   [1:DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [CB-1:0]       rem_i, rem_n;
		logic [IDX_BITS-1:0] q_i, q_n;
		logic                l_i, v_i;

		if (k == 0) begin : g_src_in
			assign rem_i = '0;
			assign q_i   = pixel_index;
			assign l_i   = roi_last;
			assign v_i   = pix_valid;
		end else begin : g_src_prev
			assign rem_i = d_rem_s[k];
			assign q_i   = d_q_s[k];
			assign l_i   = d_l_s[k];
			assign v_i   = d_v_s[k];
		end

		always_comb begin
			logic [CB:0] t;
			rem_n = rem_i;
			q_n   = q_i;
			for (int b = 0; b < DIV_BPS; b++) begin
				t   = {rem_n, q_n[IDX_BITS-1]};
				q_n = {q_n[IDX_BITS-2:0], 1'b0};
				if (t >= w_eff) begin
					t      = t - w_eff;
					q_n[0] = 1'b1;
				end
				rem_n = t[CB-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_rem_s[k+1] <= rem_n;
				d_q_s[k+1]   <= q_n;
				d_l_s[k+1]   <= l_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d_v_s[k+1] <= 1'b0;
			else if (en) d_v_s[k+1] <= v_i;
		end
	end

	// multiply stage: x = remainder, y = quotient
	logic signed [XP-1:0] pxx_s1, pyx_s1;
	logic signed [YP-1:0] pxy_s1, pyy_s1;
	logic                 m_l_s1, m_v_s1;
	logic signed [CB:0]       x_sg;
	logic signed [IDX_BITS:0] y_sg;

	assign x_sg = signed'({1'b0, d_rem_s[DIV_STAGES]});
	assign y_sg = signed'({1'b0, d_q_s[DIV_STAGES]});

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s1 <= cxx_q * x_sg;
			pyx_s1 <= cyx_q * x_sg;
			pxy_s1 <= cxy_q * y_sg;
			pyy_s1 <= cyy_q * y_sg;
			m_l_s1 <= d_l_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_v_s1 <= 1'b0;
		else if (en) m_v_s1 <= d_v_s[DIV_STAGES];
	end

	// sum stage: products plus scaled offsets
	logic signed [SW-1:0] mx_s2, my_s2;
	logic                 a_l_s2, a_v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2  <= SW'(pxx_s1) + SW'(pxy_s1) + (SW'(offx_q) <<< (FRAC_BITS - OFF_FRAC));
			my_s2  <= SW'(pyx_s1) + SW'(pyy_s1) + (SW'(offy_q) <<< (FRAC_BITS - OFF_FRAC));
			a_l_s2 <= m_l_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) a_v_s2 <= 1'b0;
		else if (en) a_v_s2 <= m_v_s1;
	end

	// clamp stage: floor and fraction flag per axis
	logic signed [SW-1:0] topx, topy, vx, vy;
	logic [CB-1:0]        fx_s3, fy_s3;
	logic                 dx_s3, dy_s3, c_l_s3, c_v_s3;

	assign topx = SW'(w_eff - 1'b1) <<< FRAC_BITS;
	assign topy = SW'(h_eff - 1'b1) <<< FRAC_BITS;

	always_comb begin
		if (mx_s2 < 0)         vx = '0;
		else if (mx_s2 > topx) vx = topx;
		else                   vx = mx_s2;
		if (my_s2 < 0)         vy = '0;
		else if (my_s2 > topy) vy = topy;
		else                   vy = my_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s3  <= vx[FRAC_BITS +: CB];
			fy_s3  <= vy[FRAC_BITS +: CB];
			dx_s3  <= |vx[FRAC_BITS-1:0];
			dy_s3  <= |vy[FRAC_BITS-1:0];
			c_l_s3 <= a_l_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_v_s3 <= 1'b0;
		else if (en) c_v_s3 <= a_v_s2;
	end

	// index stage: corner indices, packed in emit order
	logic [2*CB:0] row0, row1;
	logic [CB:0]   cx_w, cy_w;
	idx_t          i00, i10, i01, i11;
	idx_t          ix_list_s4 [0:3];
	logic [1:0]    ix_cnt_s4;
	logic          ix_l_s4;

	assign cy_w = (CB+1)'(fy_s3) + (CB+1)'(dy_s3);
	assign cx_w = (CB+1)'(fx_s3) + (CB+1)'(dx_s3);
	assign row0 = (2*CB+1)'(fy_s3 * w_eff);
	assign row1 = (2*CB+1)'(cy_w[CB-1:0] * w_eff);
	assign i00  = IDX_BITS'(32'(row0) + 32'(fx_s3));
	assign i10  = IDX_BITS'(32'(row0) + 32'(cx_w));
	assign i01  = IDX_BITS'(32'(row1) + 32'(fx_s3));
	assign i11  = IDX_BITS'(32'(row1) + 32'(cx_w));

	always_ff @(posedge clk) begin
		if (en) begin
			ix_list_s4[0] <= i00;
			ix_list_s4[1] <= dx_s3 ? i10 : i01;
			ix_list_s4[2] <= i01;
			ix_list_s4[3] <= i11;
			ix_cnt_s4     <= {dx_s3 & dy_s3, dx_s3 | dy_s3};
			ix_l_s4       <= c_l_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ix_v_s4 <= 1'b0;
		else if (en) ix_v_s4 <= c_v_s3;
	end

	// corner emitter: one result per transfer
	idx_t       e_list_q [0:3];
	logic [1:0] e_cnt_q, e_ptr_q;
	logic       e_v_q, e_l_q, e_fin;

	assign e_fin     = (e_ptr_q == e_cnt_q);
	assign emit_free = ~e_v_q | (tgt_ready & e_fin);

	always_ff @(posedge clk) begin
		if (emit_free && ix_v_s4) begin
			e_list_q <= ix_list_s4;
			e_cnt_q  <= ix_cnt_s4;
			e_l_q    <= ix_l_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_v_q   <= 1'b0;
			e_ptr_q <= '0;
		end else if (emit_free) begin
			e_v_q   <= ix_v_s4;
			e_ptr_q <= '0;
		end else if (tgt_ready) begin
			e_ptr_q <= e_ptr_q + 2'd1;
		end
	end

	assign tgt_valid    = e_v_q;
	assign target_index = e_list_q[e_ptr_q];
	assign point_last   = e_fin;
	assign roi_end      = e_fin & e_l_q;

endmodule

/* sv/apir_checker.sv */
// Port-level checks for the affine pixel index remap core, with bind.
// Depends on apir_pkg.
module apir_port_checks (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          tgt_valid,
	input logic                          tgt_ready,
	input logic [apir_pkg::IDX_BITS-1:0] target_index,
	input logic                          point_last,
	input logic                          roi_end,
	input logic                          pready
);
	// a stalled result holds its index
	a_hold_idx: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_valid && !tgt_ready |=> tgt_valid && $stable(target_index))
		else $error("target_index changed while stalled");

	// region end only on the final corner of a point
	a_roi_end: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_valid && roi_end |-> point_last)
		else $error("roi_end without point_last");

	// a point that is not finished continues after its transfer
	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_valid && tgt_ready && !point_last |=> tgt_valid)
		else $error("point dropped before its last corner");

	// register port never waits
	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");
endmodule

bind affine_pixel_index_remap_core apir_port_checks u_apir_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tgt_valid    (tgt_valid),
	.tgt_ready    (tgt_ready),
	.target_index (target_index),
	.point_last   (point_last),
	.roi_end      (roi_end),
	.pready       (pready)
);

/* sim/apir_checker.sv */
// Checker for the affine pixel index remap core: watches both channels,
// predicts corner results per accepted pixel and compares. Depends on apir_pkg.
module apir_checker
	import apir_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	input  logic                 pix_ready,
	input  logic [IDX_BITS-1:0]  pixel_index,
	input  logic                 roi_last,
	input  logic                 tgt_valid,
	input  logic                 tgt_ready,
	input  logic [IDX_BITS-1:0]  target_index,
	input  logic                 point_last,
	input  logic                 roi_end,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output int                   fail_count,
	output int                   pending,
	output int                   corner_count
);
	localparam int CB = 12;
	localparam int FB = 16;

	typedef struct packed {
		logic [IDX_BITS-1:0] index;
		logic                pt_last;
		logic                roi;
	} corner_t;

	corner_t corner_q[$];

	// shadow of the register file
	logic [DIM_BITS-1:0] width_r, height_r;
	logic signed [COEF_BITS-1:0] xx_r, xy_r, yx_r, yy_r;
	logic signed [OFF_BITS-1:0] offx_r, offy_r;

	assign pending = corner_q.size();

	function automatic longint dim_limit(logic [DIM_BITS-1:0] d);
		if (d == 0) return 1;
		if (d > (1 << CB)) return 1 << CB;
		return d;
	endfunction

	// clamp to [0, lim-1] in fixed point, give floor and ceil
	task automatic clamp_corner(input longint v, input longint lim,
			output longint fl, output longint ce);
		longint top;
		top = (lim - 1) <<< FB;
		if (v < 0) v = 0;
		if (v > top) v = top;
		fl = v >>> FB;
		ce = fl + ((v & ((1 << FB) - 1)) != 0);
	endtask

	task automatic predict_corners(input logic [IDX_BITS-1:0] idx, input logic rl);
		longint w, h, x, y, mx, my, fx, cx, fy, cy;
		longint lst[$];
		corner_t c;
		w = dim_limit(width_r);
		h = dim_limit(height_r);
		x = idx % w;
		y = idx / w;
		mx = longint'(xx_r) * x + longint'(xy_r) * y + (longint'(offx_r) <<< (FB - OFF_FRAC));
		my = longint'(yx_r) * x + longint'(yy_r) * y + (longint'(offy_r) <<< (FB - OFF_FRAC));
		clamp_corner(mx, w, fx, cx);
		clamp_corner(my, h, fy, cy);
		lst = {lst, fx + fy * w};
		if (cx != fx) lst = {lst, cx + fy * w};
		if (cy != fy) begin
			lst = {lst, fx + cy * w};
			if (cx != fx) lst = {lst, cx + cy * w};
		end
		foreach (lst[k]) begin
			c.index   = lst[k][IDX_BITS-1:0];
			c.pt_last = (k == lst.size() - 1);
			c.roi     = c.pt_last ? rl : 1'b0;
			corner_q = {corner_q, c};
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	// register writes, transfers in, transfers out
	always @(posedge clk or negedge arst_n) begin
		corner_t exp_c;
		if (!arst_n) begin
			width_r  <= RST_DIM;
			height_r <= RST_DIM;
			xx_r <= RST_UNIT;
			xy_r <= '0;
			yx_r <= '0;
			yy_r <= RST_UNIT;
			offx_r <= '0;
			offy_r <= '0;
			fail_count = 0;
			corner_count = 0;
			corner_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_BITS-1:2])
					REG_WIDTH:  width_r  <= pwdata[DIM_BITS-1:0];
					REG_HEIGHT: height_r <= pwdata[DIM_BITS-1:0];
					REG_XX:     xx_r     <= pwdata[COEF_BITS-1:0];
					REG_XY:     xy_r     <= pwdata[COEF_BITS-1:0];
					REG_YX:     yx_r     <= pwdata[COEF_BITS-1:0];
					REG_YY:     yy_r     <= pwdata[COEF_BITS-1:0];
					REG_OFFX:   offx_r   <= pwdata[OFF_BITS-1:0];
					REG_OFFY:   offy_r   <= pwdata[OFF_BITS-1:0];
					default: ;
				endcase
			end
			if (pix_valid && pix_ready)
				predict_corners(pixel_index, roi_last);
			if (tgt_valid && tgt_ready) begin
				corner_count++;
				if (corner_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result index %0d", target_index));
				end else begin
					exp_c = corner_q.pop_front();
					if (target_index !== exp_c.index)
						report_mismatch($sformatf("target_index %0d, expected %0d",
							target_index, exp_c.index));
					if (point_last !== exp_c.pt_last)
						report_mismatch($sformatf("point_last %0b, expected %0b",
							point_last, exp_c.pt_last));
					if (roi_end !== exp_c.roi)
						report_mismatch($sformatf("roi_end %0b, expected %0b",
							roi_end, exp_c.roi));
				end
			end
		end
	end

endmodule

/* sim/tb_affine_pixel_index_remap_core.sv */
// Testbench top for the affine pixel index remap core: clock, reset, APB
// setup, pixel stimulus and verdict. Depends on apir_pkg and apir_checker.
module tb_affine_pixel_index_remap_core;
	import apir_pkg::*;

	localparam int LIMIT_CYCLES = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	logic [IDX_BITS-1:0] pixel_index = '0;
	logic roi_last = 1'b0;
	logic tgt_valid;
	logic tgt_ready = 1'b0;
	logic [IDX_BITS-1:0] target_index;
	logic point_last, roi_end;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic pready;

	int fail_count, pending, corner_count;
	int cycle_count = 0;
	int pixel_count = 0;
	bit calm = 1'b0;

	affine_pixel_index_remap_core i_dut (.*);

	apir_checker i_chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("tb_affine_pixel_index_remap_core NOT OK");
			$finish;
		end
	end

	// receiver side: random stall bursts, none in the calm tail
	initial begin
		int n;
		wait (arst_n);
		forever begin
			@(posedge clk);
			tgt_ready <= 1'b1;
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 16);
				tgt_ready <= 1'b0;
				repeat (n) @(posedge clk);
				tgt_ready <= 1'b1;
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [DATA_BITS-1:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain_wait();
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// one pixel transfer, with optional random sender gap first
	task automatic send_pixel(input logic [IDX_BITS-1:0] idx, input logic rl);
		if (!calm && $urandom_range(0, 5) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel_index <= idx;
		roi_last <= rl;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		pixel_count++;
	endtask

	task automatic end_burst();
		pix_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_map(input int w, input int h, input int cxx, input int cxy,
			input int cyx, input int cyy, input int ox, input int oy);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_XX, cxx);
		reg_write(REG_XY, cxy);
		reg_write(REG_YX, cyx);
		reg_write(REG_YY, cyy);
		reg_write(REG_OFFX, ox);
		reg_write(REG_OFFY, oy);
	endtask

	// random index biased toward the image, with some far beyond it
	function automatic logic [IDX_BITS-1:0] rand_index(int w, int h);
		if ($urandom_range(0, 3) == 0) return $urandom();
		return $urandom_range(0, w * h + w);
	endfunction

	initial begin
		int w, h;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset identity map, extreme indices and both roi flags
		send_pixel('0, 1'b0);
		send_pixel(24'hFFFFFF, 1'b1);
		send_pixel(24'd513, 1'b0);
		send_pixel(24'h555555, 1'b1);
		send_pixel(24'hAAAAAA, 1'b0);
		end_burst();
		drain_wait();

		// half-pixel scale: fractional corners giving 2 and 4 results
		set_map(7, 5, 32768, 0, 0, 32768, 128, 0);
		for (int i = 0; i < 8; i++) send_pixel(i * 5, i[0]);
		end_burst();
		drain_wait();

		// extremes: zero dims, most negative and positive weights and offsets
		set_map(0, 0, 19'h40000, 19'h3FFFF, 19'h3FFFF, 19'h40000, 22'h200000, 22'h1FFFFF);
		send_pixel(24'd3, 1'b1);
		send_pixel(24'hFFFFFF, 1'b0);
		end_burst();
		drain_wait();
		set_map(13'h1FFF, 4096, 19'h3FFFF, 19'h40000, 19'h40000, 19'h3FFFF,
			22'h1FFFFF, 22'h200000);
		send_pixel(24'hFFFFFF, 1'b1);
		send_pixel(24'h000FFF, 1'b0);
		send_pixel(24'd4097, 1'b1);
		end_burst();
		drain_wait();

		// random phases with random maps
		for (int ph = 0; ph < 6; ph++) begin
			w = $urandom_range(1, 40);
			h = $urandom_range(1, 40);
			if (ph == 5) begin
				w = 4096; h = 4096;
			end
			set_map(w, h, $urandom_range(0, 19'h7FFFF) - 19'h40000 + 19'h40000 & 19'h7FFFF,
				$urandom() & 19'h7FFFF, $urandom() & 19'h7FFFF, $urandom() & 19'h7FFFF,
				$urandom() & 22'h3FFFFF, $urandom() & 22'h3FFFFF);
			if (ph % 2 == 0) begin
				// rotation-like map with small offsets keeps most corners inside
				reg_write(REG_XX, $urandom_range(30000, 70000));
				reg_write(REG_YY, $urandom_range(30000, 70000));
				reg_write(REG_XY, $urandom_range(0, 20000));
				reg_write(REG_YX, (-$urandom_range(0, 20000)) & 19'h7FFFF);
				reg_write(REG_OFFX, $urandom_range(0, 2000));
				reg_write(REG_OFFY, $urandom_range(0, 2000));
			end
			if (ph == 5) calm = 1'b1;
			for (int i = 0; i < 32; i++) send_pixel(rand_index(w, h), $urandom_range(0, 1));
			end_burst();
			drain_wait();
		end

		$display("covered %0d pixels and %0d corner results over directed and random maps",
			pixel_count, corner_count);
		if (fail_count == 0)
			$display("tb_affine_pixel_index_remap_core OK");
		else
			$display("tb_affine_pixel_index_remap_core NOT OK");
		$finish;
	end

endmodule
